@@ src/afsp_pkg.sv @@
// Shared types, constants and the sample rate table for the ADTS sync probe.
package afsp_pkg;

  localparam logic [7:0]  SYNC_BYTE         = 8'hFF;
  localparam logic [7:0]  SYNC_MASK         = 8'hF6;
  localparam logic [7:0]  SYNC_MATCH        = 8'hF0;
  localparam logic [3:0]  RATE_IDX_MAX      = 4'd11;
  localparam logic [2:0]  HDR_LAST          = 3'd6;
  localparam logic [2:0]  HDR_STORED        = 3'd5;
  localparam logic [12:0] HDR_LEN           = 13'd8;
  localparam logic [16:0] CONSUMED_MAX      = 17'h1FFFF;
  localparam logic [15:0] PROBE_LIMIT_RST   = 16'd32768;
  localparam logic [3:0]  FRAMES_NEEDED_RST = 4'd8;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_COLLECT = 2'd1,
    PH_SKIP    = 2'd2
  } phase_t;

  typedef enum logic [0:0] {
    CFG_PROBE_LIMIT   = 1'b0,
    CFG_FRAMES_NEEDED = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  frames_seen;
    logic [16:0] sample_rate_hz;
  } out_t;

  // Decoded view of one collected header
  typedef struct packed {
    logic        ok;
    logic [16:0] rate_hz;
    logic [12:0] frame_len;
  } hdr_info_t;

  function automatic logic [16:0] rate_lookup(input logic [3:0] idx);
    logic [16:0] r;
    unique case (idx)
      4'd0:    r = 17'd96000;
      4'd1:    r = 17'd88200;
      4'd2:    r = 17'd64000;
      4'd3:    r = 17'd48000;
      4'd4:    r = 17'd44100;
      4'd5:    r = 17'd32000;
      4'd6:    r = 17'd24000;
      4'd7:    r = 17'd22050;
      4'd8:    r = 17'd16000;
      4'd9:    r = 17'd12000;
      4'd10:   r = 17'd11025;
      4'd11:   r = 17'd8000;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

@@ src/afsp_hdr_chk.sv @@
// Header decode: sync nibble, rate index and 13-bit frame length checks.
module afsp_hdr_chk (
  input  logic [4:0][7:0]        hdr_bytes,
  output afsp_pkg::hdr_info_t    hdr_info
);

  logic       sync_ok;
  logic [3:0] rate_idx;
  logic       rate_ok;
  logic [12:0] frame_len;

  assign sync_ok   = (hdr_bytes[0] & afsp_pkg::SYNC_MASK) == afsp_pkg::SYNC_MATCH;
  assign rate_idx  = hdr_bytes[1][5:2];
  assign rate_ok   = rate_idx <= afsp_pkg::RATE_IDX_MAX;
  assign frame_len = {hdr_bytes[2][1:0], hdr_bytes[3], hdr_bytes[4][7:5]};

  assign hdr_info.ok        = sync_ok && rate_ok && (frame_len != 13'd0);
  assign hdr_info.rate_hz   = afsp_pkg::rate_lookup(rate_idx);
  assign hdr_info.frame_len = frame_len;

endmodule

@@ src/adts_frame_sync_probe.sv @@
// ADTS frame sync probe: top level with input stage, probe state and result register.
//
// Usage: stream file bytes on the in_ channel, one word per byte; a word with
// end_of_data set carries no byte and closes the probe. The probe hunts for 0xFF,
// collects the seven header bytes after it, checks sync, rate index and frame
// length, and skips the rest of each valid frame. It emits one out_ word when
// frames_needed headers are counted (found=1), when the byte budget probe_limit
// is exceeded while hunting or at a header or frame end, or at end of data
// (found=0), then starts over. Most bytes produce no result.
// Path: the byte that decides a result passes the input stage register and then
// the result register before the result word is valid on out_.
// Throughput: one byte per cycle unless a result stalls; the state update
// between the input stage and the result register is combinational.
// Stall: while an undelivered result sits in the output register and out_ready
// is low, the input stage holds one byte and in_ready drops once it is full.
// Config: cfg_ writes are always accepted; write only while the probe is idle.
// Reset: probe_limit=32768, frames_needed=8, probe state cleared, no result.
module adts_frame_sync_probe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  afsp_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output afsp_pkg::out_t      out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  // configuration
  logic [15:0] probe_limit_r;
  logic [3:0]  frames_needed_r;

  // input stage
  logic          s_valid_r;
  afsp_pkg::in_t s_data_r;

  // probe state
  afsp_pkg::phase_t phase_r, phase_nxt;
  logic [16:0]      cnt_r, cnt_nxt;
  logic [4:0][7:0]  hb_r, hb_nxt;
  logic [2:0]       hidx_r, hidx_nxt;
  logic [12:0]      skip_r, skip_nxt;
  logic [3:0]       fc_r, fc_nxt;
  logic [16:0]      rate_r, rate_nxt;

  // result register
  logic           out_valid_r;
  afsp_pkg::out_t out_data_r, out_data_nxt;

  afsp_pkg::hdr_info_t hdr;

  logic        go;
  logic [7:0]  b;
  logic        eod;
  logic        is_sync;
  logic [16:0] cnt_inc;
  logic        over;
  logic        hdr_done;
  logic [3:0]  fc_inc;
  logic [3:0]  need;
  logic        hit;
  logic        fl_long;
  logic        skip_end;
  logic        hdr_take;
  logic        emit;
  logic        emit_found;

  afsp_hdr_chk u_hdr_chk (
    .hdr_bytes (hb_r),
    .hdr_info  (hdr)
  );

  // a byte is processed whenever the result register can take a word
  assign go       = s_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s_valid_r || go;
  assign cfg_ready = 1'b1;

  assign b        = s_data_r.data_byte;
  assign eod      = s_data_r.end_of_data;
  assign is_sync  = b == afsp_pkg::SYNC_BYTE;
  assign cnt_inc  = (cnt_r == afsp_pkg::CONSUMED_MAX) ? cnt_r : cnt_r + 17'd1;
  assign over     = cnt_inc > {1'b0, probe_limit_r};
  assign hdr_done = hidx_r == afsp_pkg::HDR_LAST;
  assign fc_inc   = fc_r + 4'd1;
  assign need     = (frames_needed_r == 4'd0) ? 4'd1 : frames_needed_r;
  assign hit      = fc_inc >= need;
  assign fl_long  = hdr.frame_len > afsp_pkg::HDR_LEN;
  assign skip_end = skip_r <= 13'd1;
  assign hdr_take = !eod && (phase_r == afsp_pkg::PH_COLLECT) && hdr_done && hdr.ok;

  // result decision
  always_comb begin
    emit       = 1'b0;
    emit_found = 1'b0;
    if (eod) begin
      emit = 1'b1;
    end else begin
      unique case (phase_r)
        afsp_pkg::PH_HUNT: begin
          emit = !is_sync && over;
        end
        afsp_pkg::PH_COLLECT: begin
          if (hdr_done) begin
            priority if (!hdr.ok) begin
              emit = over;
            end else if (hit) begin
              emit       = 1'b1;
              emit_found = 1'b1;
            end else if (!fl_long) begin
              emit = over;
            end else begin
              emit = 1'b0;
            end
          end
        end
        afsp_pkg::PH_SKIP: begin
          if (skip_end) emit = over;
        end
        default: emit = 1'b0;
      endcase
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (go) begin
      if (eod || emit) begin
        phase_nxt = afsp_pkg::PH_HUNT;
      end else begin
        unique case (phase_r)
          afsp_pkg::PH_HUNT: begin
            if (is_sync) phase_nxt = afsp_pkg::PH_COLLECT;
          end
          afsp_pkg::PH_COLLECT: begin
            if (hdr_done) begin
              phase_nxt = (hdr.ok && fl_long) ? afsp_pkg::PH_SKIP : afsp_pkg::PH_HUNT;
            end
          end
          afsp_pkg::PH_SKIP: begin
            if (skip_end) phase_nxt = afsp_pkg::PH_HUNT;
          end
          default: phase_nxt = afsp_pkg::PH_HUNT;
        endcase
      end
    end
  end

  // datapath and result word
  always_comb begin
    cnt_nxt  = cnt_r;
    hb_nxt   = hb_r;
    hidx_nxt = hidx_r;
    skip_nxt = skip_r;
    fc_nxt   = fc_r;
    rate_nxt = rate_r;

    out_data_nxt.found          = emit_found;
    out_data_nxt.frames_seen    = hdr_take ? fc_inc : fc_r;
    out_data_nxt.sample_rate_hz = hdr_take ? hdr.rate_hz : rate_r;

    if (go) begin
      if (eod || emit) begin
        cnt_nxt  = '0;
        hidx_nxt = '0;
        skip_nxt = '0;
        fc_nxt   = '0;
        rate_nxt = '0;
      end else begin
        cnt_nxt = cnt_inc;
        unique case (phase_r)
          afsp_pkg::PH_HUNT: begin
            if (is_sync) hidx_nxt = '0;
          end
          afsp_pkg::PH_COLLECT: begin
            if (hidx_r < afsp_pkg::HDR_STORED) hb_nxt[hidx_r] = b;
            hidx_nxt = hdr_done ? 3'd0 : hidx_r + 3'd1;
            if (hdr_take) begin
              fc_nxt   = fc_inc;
              rate_nxt = hdr.rate_hz;
              if (fl_long) skip_nxt = hdr.frame_len - afsp_pkg::HDR_LEN;
            end
          end
          afsp_pkg::PH_SKIP: begin
            if (skip_r != 13'd0) skip_nxt = skip_r - 13'd1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_limit_r   <= afsp_pkg::PROBE_LIMIT_RST;
      frames_needed_r <= afsp_pkg::FRAMES_NEEDED_RST;
      s_valid_r       <= 1'b0;
      phase_r         <= afsp_pkg::PH_HUNT;
      cnt_r           <= '0;
      hidx_r          <= '0;
      skip_r          <= '0;
      fc_r            <= '0;
      rate_r          <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (afsp_pkg::cfg_reg_t'(cfg_index))
          afsp_pkg::CFG_PROBE_LIMIT:   probe_limit_r   <= cfg_data;
          afsp_pkg::CFG_FRAMES_NEEDED: frames_needed_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        s_valid_r <= 1'b1;
      end else if (go) begin
        s_valid_r <= 1'b0;
      end
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      hidx_r  <= hidx_nxt;
      skip_r  <= skip_nxt;
      fc_r    <= fc_nxt;
      rate_r  <= rate_nxt;
      if (go && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s_data_r <= in_data;
    hb_r <= hb_nxt;
    if (go && emit) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == afsp_pkg::PH_SKIP |-> skip_r != 13'd0)
    else $error("skip phase with empty skip count");

  a_hidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == afsp_pkg::PH_COLLECT |-> hidx_r <= afsp_pkg::HDR_LAST)
    else $error("header index past last header byte");

  a_found_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.found |-> out_data_r.frames_seen != 4'd0)
    else $error("found reported with no frames");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    go && emit |=> cnt_r == 17'd0 && fc_r == 4'd0 && phase_r == afsp_pkg::PH_HUNT)
    else $error("probe did not restart after a result");
`endif

endmodule
